FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers clocked on clk_i, disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BFAE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold whenever the antecedent holds
`define BFAE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bfae_pkg.sv
// ----------------------------------------------------------------------------
// bfae_pkg
// types and constants of the bit field access engine
// ----------------------------------------------------------------------------
package bfae_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned LenW   = 7;
  localparam int unsigned ValW   = 64;
  localparam int unsigned UsedW  = 13;
  localparam int unsigned IdxW   = 17;
  localparam logic [UsedW-1:0] UsedReset = 13'd4096;

  typedef enum logic [1:0] {
    OP_RD_BITS  = 2'd0,
    OP_WR_BITS  = 2'd1,
    OP_RD_BYTES = 2'd2,
    OP_WR_BYTES = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    STS_OK     = 3'd0,
    STS_RO     = 3'd1,
    STS_LEN    = 3'd2,
    STS_RANGE  = 3'd3,
    STS_BOUNDS = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_USED_SIZE = 1'b0,
    CFG_READ_ONLY = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    STATE_CLEAR  = 5'b00001,
    STATE_IDLE   = 5'b00010,
    STATE_CHECK  = 5'b00100,
    STATE_ACCESS = 5'b01000,
    STATE_DONE   = 5'b10000
  } state_e;

  typedef struct packed {
    status_e           status;
    logic              is_write;
    logic [IdxW-1:0]   fb;
    logic [IdxW-1:0]   lb;
    logic [2:0]        fofs;
    logic [2:0]        lofs;
    logic [3:0]        nb;
  } geom_t;

endpackage

FILE: rtl/bfae_check.sv
// ----------------------------------------------------------------------------
// bfae_check
// access checks and byte span of one field access
// ----------------------------------------------------------------------------
module bfae_check #(
  parameter int unsigned BUF_BYTES = 4096
) (
  input  bfae_pkg::opcode_e               opcode_i,
  input  logic [bfae_pkg::PosW-1:0]       position_i,
  input  logic [bfae_pkg::LenW-1:0]       length_i,
  input  logic [bfae_pkg::ValW-1:0]       write_value_i,
  input  logic [bfae_pkg::UsedW-1:0]      used_size_i,
  input  logic                            read_only_i,
  output bfae_pkg::geom_t                 geom_o
);

  localparam logic [bfae_pkg::IdxW-1:0] BufBytes = bfae_pkg::IdxW'(BUF_BYTES);

  logic                          is_write;
  logic                          is_bits;
  logic [bfae_pkg::LenW-1:0]     len_max;
  logic [9:0]                    lbits;
  logic [18:0]                   fbit;
  logic [19:0]                   lbit;
  logic [bfae_pkg::IdxW-1:0]     lb;
  logic [bfae_pkg::IdxW-1:0]     fb;
  logic [bfae_pkg::IdxW-1:0]     used_ext;
  logic [bfae_pkg::IdxW-1:0]     used_eff;

  always_comb begin
    is_write = (opcode_i == bfae_pkg::OP_WR_BITS) || (opcode_i == bfae_pkg::OP_WR_BYTES);
    is_bits  = opcode_i inside {bfae_pkg::OP_RD_BITS, bfae_pkg::OP_WR_BITS};
    len_max  = is_bits ? 7'd32 : 7'd8;
    lbits    = is_bits ? {3'b000, length_i} : {length_i, 3'b000};
    fbit     = is_bits ? {3'b000, position_i} : {position_i, 3'b000};
    lbit     = {1'b0, fbit} + {10'd0, lbits} - 20'd1;
    lb       = lbit[19:3];
    fb       = {1'b0, fbit[18:3]};
    used_ext = {4'd0, used_size_i};
    used_eff = (used_ext > BufBytes) ? BufBytes : used_ext;

    if (is_write && read_only_i) begin
      geom_o.status = bfae_pkg::STS_RO;
    end else if ((length_i == '0) || (length_i > len_max)) begin
      geom_o.status = bfae_pkg::STS_LEN;
    end else if (is_write && ((write_value_i >> lbits) != '0)) begin
      geom_o.status = bfae_pkg::STS_RANGE;
    end else if (lb >= used_eff) begin
      geom_o.status = bfae_pkg::STS_BOUNDS;
    end else begin
      geom_o.status = bfae_pkg::STS_OK;
    end

    geom_o.is_write = is_write;
    geom_o.fb       = fb;
    geom_o.lb       = lb;
    geom_o.fofs     = fbit[2:0];
    geom_o.lofs     = lbit[2:0];
    geom_o.nb       = 4'(lb - fb + 17'd1);
  end

endmodule

FILE: rtl/bit_field_access_engine_top.sv
// ----------------------------------------------------------------------------
// bit_field_access_engine_top
// big-endian bit and byte field read and write on a byte-wide buffer
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel (opcode in tuser, position, length and
// write value in tdata) and each one yields exactly one result on m_axis
// (read value in tdata, status in tuser). Bits count from the msb of byte 0.
// A valid access touches the 1 to 8 buffer bytes under the field, one byte
// per cycle through the separate read and write ports of the buffer ram;
// an item rejected by a check goes from its check state straight to its
// done state without touching the buffer. One item is in work at a time;
// the next item is taken as soon as the result sits in the output register.
// After reset the buffer is zeroed by a clearing pass, one byte per cycle,
// with s_axis_tready low; cfg writes are taken at any time. used_size
// resets to 4096 and read_only to 0. While m_axis_tready is low a finished
// result stays in the output register and the following item waits in its
// done state until the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bit_field_access_engine_top #(
  parameter int unsigned BUF_BYTES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_index_i,
  input  logic [bfae_pkg::UsedW-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // position [15:0], length [22:16], write_value [86:23], zero [87]
  input  logic [87:0]                       s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_value [63:0]
  output logic [63:0]                       m_axis_tdata,
  // status [2:0]
  output logic [2:0]                        m_axis_tuser
);

  localparam int unsigned AW = $clog2(BUF_BYTES);
  localparam logic [AW-1:0] LastAddr = AW'(BUF_BYTES - 1);

  bfae_pkg::state_e                 state_q, state_d;
  logic [bfae_pkg::UsedW-1:0]       used_size_q;
  logic                             read_only_q;

  bfae_pkg::opcode_e                op_q;
  logic [bfae_pkg::PosW-1:0]        pos_q;
  logic [bfae_pkg::LenW-1:0]        len_q;
  logic [bfae_pkg::ValW-1:0]        val_q;
  bfae_pkg::geom_t                  geom;

  bfae_pkg::status_e                status_q;
  logic                             is_write_q;
  logic [AW-1:0]                    fb_q;
  logic [AW-1:0]                    lb_q;
  logic [2:0]                       fofs_q;
  logic [2:0]                       lofs_q;
  logic [AW-1:0]                    addr_q;
  logic [3:0]                       rem_q;
  logic                             pend_q;
  logic [AW-1:0]                    pend_addr_q;
  logic [63:0]                      acc_q;
  logic [71:0]                      al_q;
  logic [AW-1:0]                    clr_q;

  logic                             m_valid_q;
  logic [63:0]                      out_value_q;
  bfae_pkg::status_e                out_status_q;

  logic [7:0]                       mem [BUF_BYTES];
  logic [7:0]                       rdata_q;

  logic                             accept;
  logic                             rd_en;
  logic                             wr_rmw;
  logic                             we;
  logic [AW-1:0]                    waddr;
  logic [7:0]                       wdata;
  logic [7:0]                       wmask;
  logic [7:0]                       first_byte;
  logic                             load_out;

  bfae_check #(
    .BUF_BYTES (BUF_BYTES)
  ) u_check (
    .opcode_i      (op_q),
    .position_i    (pos_q),
    .length_i      (len_q),
    .write_value_i (val_q),
    .used_size_i   (used_size_q),
    .read_only_i   (read_only_q),
    .geom_o        (geom)
  );

  assign s_axis_tready = (state_q == bfae_pkg::STATE_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state_q == bfae_pkg::STATE_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    rd_en  = (state_q == bfae_pkg::STATE_ACCESS) && (rem_q != '0);
    wr_rmw = (state_q == bfae_pkg::STATE_ACCESS) && pend_q && is_write_q;
    wmask  = ((pend_addr_q == fb_q) ? (8'hFF >> fofs_q) : 8'hFF)
           & ((pend_addr_q == lb_q) ? (8'hFF << (~lofs_q)) : 8'hFF);
    first_byte = (pend_addr_q == fb_q) ? (rdata_q & (8'hFF >> fofs_q)) : rdata_q;
    if (state_q == bfae_pkg::STATE_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else begin
      we    = wr_rmw;
      waddr = pend_addr_q;
      wdata = (rdata_q & ~wmask) | (al_q[7:0] & wmask);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bfae_pkg::STATE_CLEAR: begin
        if (clr_q == LastAddr) state_d = bfae_pkg::STATE_IDLE;
      end
      bfae_pkg::STATE_IDLE: begin
        if (accept) state_d = bfae_pkg::STATE_CHECK;
      end
      bfae_pkg::STATE_CHECK: begin
        state_d = (geom.status == bfae_pkg::STS_OK) ? bfae_pkg::STATE_ACCESS
                                                    : bfae_pkg::STATE_DONE;
      end
      bfae_pkg::STATE_ACCESS: begin
        if (pend_q && (rem_q == '0)) state_d = bfae_pkg::STATE_DONE;
      end
      bfae_pkg::STATE_DONE: begin
        if (load_out) state_d = bfae_pkg::STATE_IDLE;
      end
      default: state_d = bfae_pkg::STATE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfae_pkg::STATE_CLEAR;
      used_size_q <= bfae_pkg::UsedReset;
      read_only_q <= 1'b0;
      clr_q       <= '0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == bfae_pkg::CFG_USED_SIZE) used_size_q <= cfg_wdata_i;
        if (cfg_index_i == bfae_pkg::CFG_READ_ONLY) read_only_q <= cfg_wdata_i[0];
      end
      if (state_q == bfae_pkg::STATE_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == bfae_pkg::STATE_CHECK) begin
        rem_q  <= geom.nb;
        pend_q <= 1'b0;
      end else if (state_q == bfae_pkg::STATE_ACCESS) begin
        if (rd_en) rem_q <= rem_q - 1'b1;
        pend_q <= rd_en;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= bfae_pkg::opcode_e'(s_axis_tuser);
      pos_q <= s_axis_tdata[15:0];
      len_q <= s_axis_tdata[22:16];
      val_q <= s_axis_tdata[86:23];
    end
    if (state_q == bfae_pkg::STATE_CHECK) begin
      status_q   <= geom.status;
      is_write_q <= geom.is_write;
      fb_q       <= geom.fb[AW-1:0];
      lb_q       <= geom.lb[AW-1:0];
      fofs_q     <= geom.fofs;
      lofs_q     <= geom.lofs;
      addr_q     <= geom.is_write ? geom.lb[AW-1:0] : geom.fb[AW-1:0];
      acc_q      <= '0;
      al_q       <= {8'd0, val_q} << (~geom.lofs);
    end else if (state_q == bfae_pkg::STATE_ACCESS) begin
      if (rd_en) begin
        addr_q      <= is_write_q ? (addr_q - 1'b1) : (addr_q + 1'b1);
        pend_addr_q <= addr_q;
      end
      if (pend_q) begin
        if (is_write_q) begin
          al_q <= al_q >> 8;
        end else begin
          acc_q <= {acc_q[55:0], first_byte};
        end
      end
    end
    if (load_out) begin
      out_status_q <= status_q;
      out_value_q  <= (is_write_q || (status_q != bfae_pkg::STS_OK)) ? '0
                                                                     : (acc_q >> (~lofs_q));
    end
  end

  // byte buffer, one read and one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[addr_q];
    if (we) mem[waddr] <= wdata;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

  `BFAE_ASSERT_IMPL(a_no_rw_same_byte, rd_en && wr_rmw, addr_q != pend_addr_q, "read and write hit one byte")
  `BFAE_ASSERT_IMPL(a_write_in_span, wr_rmw, (pend_addr_q >= fb_q) && (pend_addr_q <= lb_q), "write outside field span")
  `BFAE_ASSERT_IMPL(a_out_from_done, $rose(m_valid_q), $past(state_q == bfae_pkg::STATE_DONE), "result loaded outside done")
  `BFAE_ASSERT_IMPL(a_err_value_zero, m_valid_q && (out_status_q != bfae_pkg::STS_OK), out_value_q == '0, "nonzero value on failed access")

endmodule

FILE: tb/tb_bit_field_access_engine_top.sv
// ----------------------------------------------------------------------------
// tb_bit_field_access_engine_top
// self-checking testbench for the big-endian bit field access engine
// ----------------------------------------------------------------------------
// Drives bit and byte field reads and writes into the engine and predicts
// every result from a local copy of the byte buffer and of the used size and
// read-only registers. Directed tests cover the field extremes, each status
// and the check order. A random part follows that runs mostly in-bounds
// accesses with random data under several register settings, mixed with
// malformed items. Both stream sides idle at random, with one stretch
// without any idling.
// ----------------------------------------------------------------------------
module tb_bit_field_access_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BufBytes   = 4096;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportCap  = 50;

  typedef struct packed {
    bfae_pkg::status_e         status;
    logic [bfae_pkg::ValW-1:0] value;
  } access_result_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic [0:0]                 cfg_index_i   = '0;
  logic [bfae_pkg::UsedW-1:0] cfg_wdata_i   = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  // position [15:0], length [22:16], write_value [86:23], zero [87]
  logic [87:0]                s_axis_tdata  = '0;
  // opcode [1:0]
  logic [1:0]                 s_axis_tuser  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  // read_value [63:0]
  logic [63:0]                m_axis_tdata;
  // status [2:0]
  logic [2:0]                 m_axis_tuser;

  logic [7:0]       shadow_mem [BufBytes];
  int unsigned      used_bytes;
  logic             ro_mode;
  access_result_t   pending_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count    = 0;
  bit               tx_steady      = 1'b0;
  bit               rx_steady      = 1'b0;

  bit_field_access_engine_top #(
    .BUF_BYTES(BufBytes)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rx_steady || ($urandom_range(99) >= 24);
  end

  task automatic flag_mismatch(string msg);
    if (mismatch_count < ReportCap) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    access_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result value %h status %0d",
                                m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.value) begin
          flag_mismatch($sformatf("read_value %h, expected %h", m_axis_tdata, want.value));
        end
        if (m_axis_tuser !== want.status) begin
          flag_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser, want.status));
        end
      end
    end
  end

  // checks in order, then performs the access on the shadow buffer
  function automatic access_result_t apply_access(bfae_pkg::opcode_e op,
                                                   logic [bfae_pkg::PosW-1:0] pos,
                                                   logic [bfae_pkg::LenW-1:0] len,
                                                   logic [bfae_pkg::ValW-1:0] val);
    access_result_t            res;
    bit                        is_write;
    bit                        is_bits;
    int unsigned               pos_u;
    int unsigned               len_u;
    int unsigned               window;
    int unsigned               width_bits;
    int unsigned               last_byte;
    int unsigned               bit_idx;
    int unsigned               i;
    logic [bfae_pkg::ValW-1:0] shifted;
    res.value  = '0;
    res.status = bfae_pkg::STS_OK;
    pos_u      = pos;
    len_u      = len;
    is_write   = (op == bfae_pkg::OP_WR_BITS) || (op == bfae_pkg::OP_WR_BYTES);
    is_bits    = (op == bfae_pkg::OP_RD_BITS) || (op == bfae_pkg::OP_WR_BITS);
    window     = (used_bytes > BufBytes) ? BufBytes : used_bytes;
    width_bits = is_bits ? len_u : 8 * len_u;
    if (is_write && ro_mode) begin
      res.status = bfae_pkg::STS_RO;
    end else if (len_u == 0 || len_u > (is_bits ? 32 : 8)) begin
      res.status = bfae_pkg::STS_LEN;
    end else if (is_write && width_bits < 64 && (val >> width_bits) != 0) begin
      res.status = bfae_pkg::STS_RANGE;
    end else begin
      last_byte = is_bits ? ((pos_u + len_u - 1) >> 3) : (pos_u + len_u - 1);
      if (last_byte >= window) begin
        res.status = bfae_pkg::STS_BOUNDS;
      end
    end
    if (res.status == bfae_pkg::STS_OK) begin
      case (op)
        bfae_pkg::OP_RD_BITS: begin
          for (i = 0; i < len_u; i++) begin
            bit_idx   = pos_u + i;
            res.value = {res.value[bfae_pkg::ValW-2:0],
                         shadow_mem[bit_idx >> 3][7 - (bit_idx & 7)]};
          end
        end
        bfae_pkg::OP_WR_BITS: begin
          for (i = 0; i < len_u; i++) begin
            bit_idx = pos_u + i;
            shadow_mem[bit_idx >> 3][7 - (bit_idx & 7)] = val[len_u - 1 - i];
          end
        end
        bfae_pkg::OP_RD_BYTES: begin
          for (i = 0; i < len_u; i++) begin
            res.value = {res.value[bfae_pkg::ValW-9:0], shadow_mem[pos_u + i]};
          end
        end
        default: begin
          for (i = 0; i < len_u; i++) begin
            shifted = val >> (8 * (len_u - 1 - i));
            shadow_mem[pos_u + i] = shifted[7:0];
          end
        end
      endcase
    end
    return res;
  endfunction

  task automatic send_access(bfae_pkg::opcode_e op, logic [bfae_pkg::PosW-1:0] pos,
                             logic [bfae_pkg::LenW-1:0] len,
                             logic [bfae_pkg::ValW-1:0] val);
    while (!tx_steady && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, val, len, pos};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(apply_access(op, pos, len, val));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(bfae_pkg::cfg_reg_e idx, int unsigned value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= bfae_pkg::UsedW'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == bfae_pkg::CFG_USED_SIZE) begin
      used_bytes = value;
    end else begin
      ro_mode = value[0];
    end
  endtask

  task automatic random_accesses(int unsigned count);
    bfae_pkg::opcode_e         op;
    bit                        is_bits;
    int unsigned               window;
    int unsigned               span;
    int unsigned               len_u;
    int unsigned               n;
    logic [bfae_pkg::PosW-1:0] pos;
    logic [bfae_pkg::ValW-1:0] val;
    repeat (count) begin
      window  = (used_bytes > BufBytes) ? BufBytes : used_bytes;
      op      = bfae_pkg::opcode_e'($urandom_range(3));
      is_bits = (op == bfae_pkg::OP_RD_BITS) || (op == bfae_pkg::OP_WR_BITS);
      span    = is_bits ? window * 8 : window;
      val     = {$urandom, $urandom};
      if ($urandom_range(99) < 82) begin
        len_u = is_bits ? $urandom_range(32, 1) : $urandom_range(8, 1);
        pos   = (span > len_u) ? bfae_pkg::PosW'($urandom_range(span - len_u)) : '0;
        n     = is_bits ? len_u : 8 * len_u;
        if ($urandom_range(9) == 0) begin
          val = '1;
        end
        if (n < 64) begin
          val = val & ((64'd1 << n) - 64'd1);
        end
      end else begin
        len_u = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(33);
        case ($urandom_range(2))
          0: pos = bfae_pkg::PosW'($urandom_range(65535));
          1: pos = bfae_pkg::PosW'(span - len_u + $urandom_range(1, 3));
          default: pos = bfae_pkg::PosW'($urandom_range(span));
        endcase
        n = is_bits ? len_u : 8 * len_u;
        if ($urandom_range(1) == 0 && n < 64) begin
          val = (val & ((64'd1 << n) - 64'd1)) + (64'($urandom_range(1)) << n);
        end
      end
      send_access(op, pos, bfae_pkg::LenW'(len_u), val);
    end
  endtask

  task automatic test_field_access();
    send_access(bfae_pkg::OP_RD_BITS,  16'd0,     7'd32, 64'd0);
    send_access(bfae_pkg::OP_WR_BITS,  16'd3,     7'd13, 64'h1ABC);
    send_access(bfae_pkg::OP_WR_BITS,  16'd7,     7'd32, 64'hFFFF_FFFF);
    send_access(bfae_pkg::OP_RD_BYTES, 16'd0,     7'd8,  64'd0);
    send_access(bfae_pkg::OP_WR_BYTES, 16'd4088,  7'd8,  '1);
    send_access(bfae_pkg::OP_RD_BITS,  16'd32729, 7'd32, 64'd0);
    send_access(bfae_pkg::OP_RD_BITS,  16'd32761, 7'd8,  64'd0);
    send_access(bfae_pkg::OP_WR_BYTES, 16'd4089,  7'd8,  64'd0);
    send_access(bfae_pkg::OP_RD_BITS,  16'd65535, 7'd1,  64'd0);
  endtask

  task automatic test_length_and_range();
    send_access(bfae_pkg::OP_RD_BITS,  16'd0,     7'd0,   64'd0);
    send_access(bfae_pkg::OP_WR_BITS,  16'd0,     7'd33,  64'd0);
    send_access(bfae_pkg::OP_RD_BYTES, 16'd0,     7'd9,   64'd0);
    send_access(bfae_pkg::OP_WR_BYTES, 16'd0,     7'd127, '1);
    send_access(bfae_pkg::OP_WR_BITS,  16'd100,   7'd4,   64'd16);
    send_access(bfae_pkg::OP_WR_BYTES, 16'd10,    7'd2,   64'h1_0000);
    send_access(bfae_pkg::OP_WR_BITS,  16'd40,    7'd32,  64'h1_0000_0000);
    send_access(bfae_pkg::OP_WR_BITS,  16'd65535, 7'd1,   64'd2);
  endtask

  task automatic test_read_only();
    write_reg(bfae_pkg::CFG_READ_ONLY, 1);
    send_access(bfae_pkg::OP_WR_BITS,  16'd0, 7'd1,  64'd1);
    send_access(bfae_pkg::OP_WR_BYTES, 16'd0, 7'd0,  '1);
    send_access(bfae_pkg::OP_RD_BITS,  16'd0, 7'd16, 64'd0);
    write_reg(bfae_pkg::CFG_READ_ONLY, 0);
    send_access(bfae_pkg::OP_WR_BYTES, 16'd0, 7'd1,  64'h5A);
  endtask

  task automatic test_used_size();
    write_reg(bfae_pkg::CFG_USED_SIZE, 0);
    send_access(bfae_pkg::OP_RD_BYTES, 16'd0,    7'd1, 64'd0);
    write_reg(bfae_pkg::CFG_USED_SIZE, 8191);
    send_access(bfae_pkg::OP_RD_BYTES, 16'd4095, 7'd1, 64'd0);
    send_access(bfae_pkg::OP_RD_BYTES, 16'd4095, 7'd2, 64'd0);
    write_reg(bfae_pkg::CFG_USED_SIZE, 1);
    send_access(bfae_pkg::OP_RD_BITS,  16'd0,    7'd8, 64'd0);
    send_access(bfae_pkg::OP_RD_BITS,  16'd1,    7'd8, 64'd0);
  endtask

  task automatic test_pause_for_results();
    write_reg(bfae_pkg::CFG_USED_SIZE, 4096);
    random_accesses(20);
    drain_results();
    random_accesses(20);
  endtask

  task automatic test_random();
    write_reg(bfae_pkg::CFG_USED_SIZE, 64);
    random_accesses(700);
    write_reg(bfae_pkg::CFG_USED_SIZE, 4096);
    random_accesses(300);
    write_reg(bfae_pkg::CFG_USED_SIZE, 16);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    random_accesses(300);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (6) begin
      write_reg(bfae_pkg::CFG_USED_SIZE, $urandom_range(8191));
      write_reg(bfae_pkg::CFG_READ_ONLY, $urandom_range(1));
      random_accesses(50);
    end
    write_reg(bfae_pkg::CFG_READ_ONLY, 0);
    write_reg(bfae_pkg::CFG_USED_SIZE, 200);
    random_accesses(250);
  endtask

  initial begin
    int unsigned k;
    for (k = 0; k < BufBytes; k++) begin
      shadow_mem[k] = 8'h00;
    end
    used_bytes = 4096;
    ro_mode    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_field_access();
    test_length_and_range();
    test_read_only();
    test_used_size();
    test_pause_for_results();
    test_random();

    drain_results();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bfae_pkg.sv
rtl/bfae_check.sv
rtl/bit_field_access_engine_top.sv
tb/tb_bit_field_access_engine_top.sv
